FILE: rtl/kpt_pkg.sv
// Shared types and constants for the key pressure tracker.
package kpt_pkg;

    typedef struct packed {
        logic       action;
        logic [4:0] key_index;
        logic [9:0] filtered_value;
        logic [7:0] baseline_byte;
        logic [9:0] cal_max_delta;
    } item_t;

    typedef struct packed {
        logic [4:0]  out_key;
        logic        pressed;
        logic        note_on;
        logic        note_off;
        logic [11:0] pressure;
    } result_t;

    typedef struct packed {
        logic [8:0]  response_shape;
        logic [7:0]  deadzone_offset;
        logic [7:0]  press_fraction;
        logic [7:0]  release_fraction;
        logic [9:0]  min_press_level;
        logic [9:0]  min_release_level;
        logic [19:0] slew_step;
    } cfg_t;

    typedef struct packed {
        logic [17:0] a;
        logic [17:0] b;
    } mul_req_t;

    typedef struct packed {
        logic       start;
        logic [9:0] num;
        logic [9:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [15:0] quo;
    } div_rsp_t;

    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_CAL    = 1'b1;

    localparam logic [2:0] REG_SHAPE    = 3'd0;
    localparam logic [2:0] REG_DEADZONE = 3'd1;
    localparam logic [2:0] REG_PRESS_FR = 3'd2;
    localparam logic [2:0] REG_REL_FR   = 3'd3;
    localparam logic [2:0] REG_MIN_PRESS = 3'd4;
    localparam logic [2:0] REG_MIN_REL  = 3'd5;
    localparam logic [2:0] REG_SLEW     = 3'd6;

    localparam logic [8:0]  SHAPE_RST    = 9'd128;
    localparam logic [7:0]  DEADZONE_RST = 8'd0;
    localparam logic [7:0]  PRESS_FR_RST = 8'd77;
    localparam logic [7:0]  REL_FR_RST   = 8'd51;
    localparam logic [9:0]  MIN_PRESS_RST = 10'd20;
    localparam logic [9:0]  MIN_REL_RST  = 10'd10;
    localparam logic [19:0] SLEW_RST     = 20'd25600;

    // per-key levels after reset: 400*77>>8 and 400*51>>8
    localparam logic [9:0] MAX_DELTA_RST = 10'd400;
    localparam logic [9:0] PRESS_LVL_RST = 10'd120;
    localparam logic [9:0] REL_LVL_RST   = 10'd79;

    localparam logic [8:0]  SHAPE_HALF = 9'd128;
    localparam logic [8:0]  SHAPE_FULL = 9'd256;
    localparam logic [16:0] ONE_Q16    = 17'h10000;
    localparam logic [17:0] THREE_Q16  = 18'd196608;

endpackage

FILE: rtl/kpt_regs.sv
// APB configuration register file.
module kpt_regs (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output kpt_pkg::cfg_t     cfg
);
    import kpt_pkg::*;

    cfg_t       cfg_reg;
    logic [2:0] reg_idx;

    assign reg_idx = paddr[4:2];
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.response_shape    <= SHAPE_RST;
            cfg_reg.deadzone_offset   <= DEADZONE_RST;
            cfg_reg.press_fraction    <= PRESS_FR_RST;
            cfg_reg.release_fraction  <= REL_FR_RST;
            cfg_reg.min_press_level   <= MIN_PRESS_RST;
            cfg_reg.min_release_level <= MIN_REL_RST;
            cfg_reg.slew_step         <= SLEW_RST;
        end
        else if (psel && penable && pwrite)
        begin
            case (reg_idx)
                REG_SHAPE:     cfg_reg.response_shape    <= pwdata[8:0];
                REG_DEADZONE:  cfg_reg.deadzone_offset   <= pwdata[7:0];
                REG_PRESS_FR:  cfg_reg.press_fraction    <= pwdata[7:0];
                REG_REL_FR:    cfg_reg.release_fraction  <= pwdata[7:0];
                REG_MIN_PRESS: cfg_reg.min_press_level   <= pwdata[9:0];
                REG_MIN_REL:   cfg_reg.min_release_level <= pwdata[9:0];
                REG_SLEW:      cfg_reg.slew_step         <= pwdata[19:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_SHAPE:     prdata = {23'd0, cfg_reg.response_shape};
            REG_DEADZONE:  prdata = {24'd0, cfg_reg.deadzone_offset};
            REG_PRESS_FR:  prdata = {24'd0, cfg_reg.press_fraction};
            REG_REL_FR:    prdata = {24'd0, cfg_reg.release_fraction};
            REG_MIN_PRESS: prdata = {22'd0, cfg_reg.min_press_level};
            REG_MIN_REL:   prdata = {22'd0, cfg_reg.min_release_level};
            REG_SLEW:      prdata = {12'd0, cfg_reg.slew_step};
            default:       prdata = 32'd0;
        endcase
    end

endmodule

FILE: rtl/kpt_mul.sv
// Shared 18x18 multiplier with registered product.
module kpt_mul (
    input  logic              clk,
    input  kpt_pkg::mul_req_t req,
    output logic [35:0]       prod
);
    import kpt_pkg::*;

    logic [35:0] prod_reg;

    assign prod = prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= {18'd0, req.a} * {18'd0, req.b};
    end

endmodule

FILE: rtl/kpt_div.sv
// Restoring divider, one quotient bit per cycle; numerator below denominator.
module kpt_div (
    input  logic              clk,
    input  logic              rst_n,
    input  kpt_pkg::div_req_t req,
    output kpt_pkg::div_rsp_t rsp
);
    import kpt_pkg::*;

    localparam int QUO_BITS = 16;

    logic        busy_reg;
    logic        done_reg;
    logic [3:0]  cnt_reg;
    logic [9:0]  rem_reg;
    logic [9:0]  den_reg;
    logic [15:0] quo_reg;
    logic [10:0] rem_shift;
    logic [10:0] rem_sub;
    logic        ge;

    assign rem_shift = {rem_reg, 1'b0};
    assign ge        = rem_shift >= {1'b0, den_reg};
    assign rem_sub   = rem_shift - {1'b0, den_reg};
    assign rsp.done  = done_reg;
    assign rsp.quo   = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= req.num;
                den_reg  <= req.den;
                quo_reg  <= '0;
            end
            else if (busy_reg)
            begin
                rem_reg <= ge ? rem_sub[9:0] : rem_shift[9:0];
                quo_reg <= {quo_reg[14:0], ge};
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'(QUO_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

FILE: rtl/key_pressure_tracker_top.sv
// Key pressure tracker top level: sequencer, per-key state and history window.
//
// Input channel item (item_valid/item_ready) carries either a sample or a
// calibration for one key. A calibration stores the key's full-press delta
// and derives press/release thresholds; it gives no result. A sample runs
// press/release hysteresis and pressure shaping and gives one result on
// res (res_valid/res_ready). Keys at or beyond KEY_COUNT are dropped.
// A sample for a key that is not held skips the divide and the shaping. For
// a held key, the divide (16 quotient bits, one per cycle) and the passes
// through the one shared multiplier (power or smoothstep side) set how long
// it takes; the divide is skipped when the normalized value is zero or one.
// One item is in work at a time; item_ready is high only when idle, so a new
// item is taken only once the last one is through.
// A finished result sits in the output register; if res_ready is low the
// sequencer waits with the next result until the register drains.
// Reset (rst_n, asynchronous) restores registers, per-key thresholds and
// clears all history at once through per-entry valid bits; no clearing pass.
// Config is to be written through the APB port only while the block is idle;
// the block itself does not enforce this.
module key_pressure_tracker_top #(
    parameter int KEY_COUNT         = 24,
    parameter int WINDOW_LEN        = 8,
    parameter int POWER_EXPONENT    = 3,
    parameter int SMOOTHSTEP_PASSES = 2,
    parameter int OUTPUT_FULL_SCALE = 4095
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  kpt_pkg::item_t    item,
    output logic              res_valid,
    input  logic              res_ready,
    output kpt_pkg::result_t  res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import kpt_pkg::*;

    localparam int KW      = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam int KXW     = (KW > 5) ? KW : 5;
    localparam int PTR_W   = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int ENTRIES = KEY_COUNT * WINDOW_LEN;
    localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int SLEW_W  = $clog2(OUTPUT_FULL_SCALE * 256 + 1);
    localparam int SUM_W   = SLEW_W + $clog2(WINDOW_LEN) + 1;
    localparam int DW      = ((SLEW_W > 20) ? SLEW_W : 20) + 2;

    typedef enum logic [4:0] {
        S_IDLE, S_CAL1, S_CAL2, S_CAL3, S_DELTA, S_DIVINIT, S_DIV, S_SHAPE,
        S_POW_MUL, S_POW_CAP, S_SQ_MUL, S_SQ_CAP, S_SM_MUL, S_SM_CAP,
        S_BL1, S_BL2, S_BL3, S_TGT_MUL, S_TGT_CAP, S_SLEW, S_HIST, S_OUT
    } state_t;

    state_t state_reg;

    // configuration and shared units
    cfg_t      cfg;
    mul_req_t  mul_req;
    logic [35:0] prod;
    div_req_t  div_req;
    div_rsp_t  div_rsp;

    // per-key state
    logic                held_reg  [KEY_COUNT];
    logic [9:0]          start_reg [KEY_COUNT];
    logic [9:0]          maxd_reg  [KEY_COUNT];
    logic [9:0]          plvl_reg  [KEY_COUNT];
    logic [9:0]          rlvl_reg  [KEY_COUNT];
    logic [SLEW_W-1:0]   slewed_reg [KEY_COUNT];
    logic [PTR_W-1:0]    ptr_reg   [KEY_COUNT];
    logic [SUM_W-1:0]    sum_reg   [KEY_COUNT];
    logic                hval_reg  [ENTRIES];

    // history memory
    logic [SLEW_W-1:0]   hist_mem [ENTRIES];
    logic [SLEW_W-1:0]   rd_reg;
    logic                rdv_reg;
    logic [AW-1:0]       addr;
    logic                hist_we;

    // working registers of one item
    item_t               item_reg;
    logic [KW-1:0]       idx_reg;
    logic [9:0]          delta_reg;
    logic                on_reg;
    logic                off_reg;
    logic [9:0]          plvl_new_reg;
    logic [16:0]         x_reg;
    logic [16:0]         y_reg;
    logic [16:0]         sq_reg;
    logic [8:0]          t_reg;
    logic [2:0]          iter_reg;
    logic [24:0]         a_reg;
    logic [16:0]         shaped_reg;
    logic [SLEW_W-1:0]   target_reg;
    logic                res_valid_reg;
    result_t             res_reg;

    // combinational helpers
    logic [KXW-1:0]      key_ext;
    logic                key_in_range;
    logic [9:0]          base;
    logic [9:0]          delta;
    logic                press_hit;
    logic                rel_hit;
    logic [10:0]         pd;
    logic [10:0]         md_ext;
    logic [10:0]         dl_ext;
    logic                div_ok;
    logic [9:0]          div_num;
    logic [9:0]          div_den;
    logic [8:0]          s_eff;
    logic [8:0]          t_pow;
    logic [8:0]          t_sm;
    logic [17:0]         smooth_fac;
    logic [24:0]         bl_sum;
    logic [9:0]          lvl_p;
    logic [9:0]          lvl_r;
    logic [9:0]          lvl_r_fix;
    logic [SLEW_W-1:0]   slewed_cur;
    logic signed [DW-1:0] diff;
    logic signed [DW-1:0] stp;
    logic [SLEW_W-1:0]   slew_new;
    logic [SLEW_W-1:0]   old_val;
    logic [SUM_W-1:0]    sum_new;
    logic [SUM_W-1:0]    avg;
    logic [SUM_W+11:0]   avg_ext;
    logic [2:0]          iter_inc;

    kpt_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    kpt_mul u_mul (
        .clk  (clk),
        .req  (mul_req),
        .prod (prod)
    );

    kpt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign item_ready = (state_reg == S_IDLE);
    assign res_valid  = res_valid_reg;
    assign res        = res_reg;

    assign key_ext      = KXW'(item.key_index);
    assign key_in_range = (int'(item.key_index) < KEY_COUNT);

    // delta and hysteresis
    assign base      = {item_reg.baseline_byte, 2'b00};
    assign delta     = (base > item_reg.filtered_value) ? base - item_reg.filtered_value : 10'd0;
    assign press_hit = !held_reg[idx_reg] && (delta > plvl_reg[idx_reg]);
    assign rel_hit   = held_reg[idx_reg] && (delta < rlvl_reg[idx_reg]);

    // normalization past start delta plus deadzone
    assign pd      = {1'b0, start_reg[idx_reg]} + {3'd0, cfg.deadzone_offset};
    assign md_ext  = {1'b0, maxd_reg[idx_reg]};
    assign dl_ext  = {1'b0, delta_reg};
    assign div_ok  = (md_ext > pd) && (dl_ext > pd);
    assign div_num = 10'(dl_ext - pd);
    assign div_den = 10'(md_ext - pd);

    assign div_req.start = (state_reg == S_DIVINIT) && div_ok && (div_num < div_den);
    assign div_req.num   = div_num;
    assign div_req.den   = div_den;

    // curve blend weight
    assign s_eff      = (cfg.response_shape > SHAPE_FULL) ? SHAPE_FULL : cfg.response_shape;
    assign t_pow      = 9'(10'd256 - {s_eff, 1'b0});
    assign t_sm       = 9'({s_eff, 1'b0} - 10'd256);
    assign smooth_fac = THREE_Q16 - {y_reg, 1'b0};
    assign bl_sum     = a_reg + prod[24:0];
    assign iter_inc   = iter_reg + 3'd1;

    // thresholds from calibration
    assign lvl_r     = (prod[17:8] < cfg.min_release_level) ? cfg.min_release_level
                                                             : prod[17:8];
    assign lvl_p     = (prod[17:8] < cfg.min_press_level) ? cfg.min_press_level
                                                           : prod[17:8];
    assign lvl_r_fix = (lvl_r >= plvl_new_reg) ?
                       ((plvl_new_reg > 10'd1) ? plvl_new_reg - 10'd1 : 10'd0) : lvl_r;

    // slew limiting
    assign slewed_cur = slewed_reg[idx_reg];
    assign diff = $signed(DW'(target_reg)) - $signed(DW'(slewed_cur));
    assign stp  = $signed(DW'(cfg.slew_step));
    always_comb
    begin
        if (diff > stp)
            slew_new = SLEW_W'(DW'(slewed_cur) + DW'(cfg.slew_step));
        else if (diff < -stp)
            slew_new = SLEW_W'(DW'(slewed_cur) - DW'(cfg.slew_step));
        else
            slew_new = target_reg;
    end

    // history window
    assign addr    = AW'(int'(idx_reg) * WINDOW_LEN + int'(ptr_reg[idx_reg]));
    assign hist_we = (state_reg == S_HIST);
    assign old_val = rdv_reg ? rd_reg : '0;
    assign sum_new = sum_reg[idx_reg] - SUM_W'(old_val) + SUM_W'(slewed_cur);
    assign avg     = SUM_W'(sum_reg[idx_reg] / WINDOW_LEN);
    assign avg_ext = (SUM_W + 12)'(avg);

    // shared multiplier operand selection
    always_comb
    begin
        mul_req.a = '0;
        mul_req.b = '0;
        case (state_reg)
            S_CAL1:
            begin
                mul_req.a = 18'(item_reg.cal_max_delta);
                mul_req.b = 18'(cfg.press_fraction);
            end
            S_CAL2:
            begin
                mul_req.a = 18'(item_reg.cal_max_delta);
                mul_req.b = 18'(cfg.release_fraction);
            end
            S_POW_MUL:
            begin
                mul_req.a = 18'(y_reg);
                mul_req.b = 18'(x_reg);
            end
            S_SQ_MUL:
            begin
                mul_req.a = 18'(y_reg);
                mul_req.b = 18'(y_reg);
            end
            S_SM_MUL:
            begin
                mul_req.a = 18'(sq_reg);
                mul_req.b = smooth_fac;
            end
            S_BL1:
            begin
                mul_req.a = 18'(x_reg);
                mul_req.b = 18'(10'd256 - {1'b0, t_reg});
            end
            S_BL2:
            begin
                mul_req.a = 18'(y_reg);
                mul_req.b = 18'(t_reg);
            end
            S_TGT_MUL:
            begin
                mul_req.a = 18'(shaped_reg);
                mul_req.b = 18'(OUTPUT_FULL_SCALE);
            end
            default:
            begin
                mul_req.a = '0;
                mul_req.b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
            hist_mem[addr] <= slewed_cur;
        rd_reg <= hist_mem[addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
            for (int k = 0; k < KEY_COUNT; k++)
            begin
                held_reg[k]   <= 1'b0;
                start_reg[k]  <= '0;
                maxd_reg[k]   <= MAX_DELTA_RST;
                plvl_reg[k]   <= PRESS_LVL_RST;
                rlvl_reg[k]   <= REL_LVL_RST;
                slewed_reg[k] <= '0;
                ptr_reg[k]    <= '0;
                sum_reg[k]    <= '0;
            end
            for (int e = 0; e < ENTRIES; e++)
                hval_reg[e] <= 1'b0;
        end
        else
        begin
            // S_OUT handles its own drain and reload of the output register
            if (res_valid_reg && res_ready && state_reg != S_OUT)
                res_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (item_valid)
                    begin
                        item_reg <= item;
                        idx_reg  <= key_ext[KW-1:0];
                        if (key_in_range)
                            state_reg <= (item.action == ACT_CAL) ? S_CAL1 : S_DELTA;
                    end
                end
                S_CAL1:
                    state_reg <= S_CAL2;
                S_CAL2:
                begin
                    plvl_new_reg <= lvl_p;
                    state_reg    <= S_CAL3;
                end
                S_CAL3:
                begin
                    maxd_reg[idx_reg] <= item_reg.cal_max_delta;
                    plvl_reg[idx_reg] <= plvl_new_reg;
                    rlvl_reg[idx_reg] <= lvl_r_fix;
                    state_reg         <= S_IDLE;
                end
                S_DELTA:
                begin
                    delta_reg <= delta;
                    on_reg    <= press_hit;
                    off_reg   <= rel_hit;
                    if (press_hit)
                    begin
                        held_reg[idx_reg]  <= 1'b1;
                        start_reg[idx_reg] <= delta;
                    end
                    if (rel_hit)
                    begin
                        held_reg[idx_reg]   <= 1'b0;
                        slewed_reg[idx_reg] <= '0;
                        sum_reg[idx_reg]    <= '0;
                        for (int j = 0; j < WINDOW_LEN; j++)
                            hval_reg[int'(idx_reg) * WINDOW_LEN + j] <= 1'b0;
                    end
                    target_reg <= '0;
                    state_reg  <= ((held_reg[idx_reg] && !rel_hit) || press_hit) ?
                                  S_DIVINIT : S_SLEW;
                end
                S_DIVINIT:
                begin
                    if (!div_ok)
                    begin
                        x_reg     <= '0;
                        state_reg <= S_SHAPE;
                    end
                    else if (div_num >= div_den)
                    begin
                        x_reg     <= ONE_Q16;
                        state_reg <= S_SHAPE;
                    end
                    else
                        state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        x_reg     <= {1'b0, div_rsp.quo};
                        state_reg <= S_SHAPE;
                    end
                end
                S_SHAPE:
                begin
                    y_reg        <= x_reg;
                    iter_reg     <= '0;
                    if (s_eff < SHAPE_HALF)
                    begin
                        t_reg     <= t_pow;
                        state_reg <= (POWER_EXPONENT > 1) ? S_POW_MUL : S_BL1;
                    end
                    else
                    begin
                        t_reg     <= t_sm;
                        state_reg <= S_SQ_MUL;
                    end
                end
                S_POW_MUL:
                    state_reg <= S_POW_CAP;
                S_POW_CAP:
                begin
                    y_reg     <= prod[32:16];
                    iter_reg  <= iter_inc;
                    state_reg <= (iter_inc == 3'(POWER_EXPONENT - 1)) ? S_BL1 : S_POW_MUL;
                end
                S_SQ_MUL:
                    state_reg <= S_SQ_CAP;
                S_SQ_CAP:
                begin
                    sq_reg    <= prod[32:16];
                    state_reg <= S_SM_MUL;
                end
                S_SM_MUL:
                    state_reg <= S_SM_CAP;
                S_SM_CAP:
                begin
                    y_reg     <= prod[32:16];
                    iter_reg  <= iter_inc;
                    state_reg <= (iter_inc == 3'(SMOOTHSTEP_PASSES)) ? S_BL1 : S_SQ_MUL;
                end
                S_BL1:
                    state_reg <= S_BL2;
                S_BL2:
                begin
                    a_reg     <= prod[24:0];
                    state_reg <= S_BL3;
                end
                S_BL3:
                begin
                    shaped_reg <= bl_sum[24:8];
                    state_reg  <= S_TGT_MUL;
                end
                S_TGT_MUL:
                    state_reg <= S_TGT_CAP;
                S_TGT_CAP:
                begin
                    target_reg <= prod[8 +: SLEW_W];
                    state_reg  <= S_SLEW;
                end
                S_SLEW:
                begin
                    // memory read of the oldest entry is issued this cycle
                    slewed_reg[idx_reg] <= slew_new;
                    rdv_reg             <= hval_reg[addr];
                    state_reg           <= S_HIST;
                end
                S_HIST:
                begin
                    hval_reg[addr]   <= 1'b1;
                    sum_reg[idx_reg] <= sum_new;
                    if (int'(ptr_reg[idx_reg]) == WINDOW_LEN - 1)
                        ptr_reg[idx_reg] <= '0;
                    else
                        ptr_reg[idx_reg] <= ptr_reg[idx_reg] + PTR_W'(1);
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!res_valid_reg || res_ready)
                    begin
                        res_valid_reg    <= 1'b1;
                        res_reg.out_key  <= item_reg.key_index;
                        res_reg.pressed  <= held_reg[idx_reg];
                        res_reg.note_on  <= on_reg;
                        res_reg.note_off <= off_reg;
                        res_reg.pressure <= avg_ext[19:8];
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    // no second item is taken while one is in work
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready && key_in_range) |=> !item_ready)
        else $error("item accepted while sequencer busy");

    // stored release threshold sits below press threshold unless that is zero
    a_levels_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DELTA) |->
        (rlvl_reg[idx_reg] < plvl_reg[idx_reg] || plvl_reg[idx_reg] == 10'd0))
        else $error("release level not below press level");

    // a result never flags both edges, and note_on implies held
    a_note_flags: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (!(res_reg.note_on && res_reg.note_off) &&
                           (!res_reg.note_on || res_reg.pressed)))
        else $error("inconsistent note flags");

    // shaped curve value stays within one in Q1.16
    a_shaped_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TGT_MUL) |-> (shaped_reg <= ONE_Q16))
        else $error("shaped value above full scale");
`endif

endmodule
